[src/rat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rat_pkg: shared types and constants of the rational accumulator
// Payload structs, mode and status codes, default width.
// ----------------------------------------------------------------------------
package rat_pkg;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAG_W = 33;
  localparam int WIDE_W = 65;

  localparam logic [2:0] MODE_LOAD = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] operand_num;
    logic signed [31:0] operand_den;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_num;
    logic [30:0]        result_den;
  } out_item_t;
endpackage

[src/rational_accumulator_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_accumulator_alu: rational accumulator with gcd reduction
//
//   channel | direction | payload           | handshake
//   in      | input     | rat_pkg::in_item_t  | in_valid / in_ready
//   out     | output    | rat_pkg::out_item_t | out_valid / out_ready
//
// One item at a time. Each product runs on a shared bit-serial multiplier
// (three for add/sub, two for mul/div), followed by the binary gcd and the two
// exact divisions on one shared restoring divider.
// Ignored modes and zero denominators answer in the cycle after the transfer.
// Reset clears the accumulator to 0/1. A held result stalls the next item.
// ----------------------------------------------------------------------------
module rational_accumulator_alu #(
  parameter int VALUE_WIDTH = rat_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rat_pkg::in_item_t  in,
  output logic               out_valid,
  input  logic               out_ready,
  output rat_pkg::out_item_t out
);
  localparam int M = rat_pkg::MAG_W;
  localparam int W = rat_pkg::WIDE_W;
  localparam logic [W-1:0] LIM = W'(1) << (VALUE_WIDTH - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_M1    = 4'd1;
  localparam logic [3:0] S_M2    = 4'd2;
  localparam logic [3:0] S_M3    = 4'd3;
  localparam logic [3:0] S_GCD   = 4'd4;
  localparam logic [3:0] S_DN    = 4'd5;
  localparam logic [3:0] S_DD    = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;

  logic [3:0] state;
  logic [2:0] mode;
  logic       on_s, od_s, an_s;
  logic [M-1:0] on_m, od_m, an_m, ad_m;
  logic signed [31:0] acc_num;
  logic [31:0]        acc_den;
  logic         t1_s, t2_s, n_s;
  logic [W-1:0] t1, n_m, d_m, g_val;
  logic [1:0]   status;

  logic         mul_start, mul_done;
  logic [M-1:0] mul_a, mul_b;
  logic [2*M-1:0] mul_p;
  logic         gcd_start, gcd_done;
  logic [W-1:0] gcd_g;
  logic         div_start, div_done;
  logic [W-1:0] div_num, div_q;

  logic [M-1:0] in_num_ext, in_den_ext;
  logic [W-1:0] t2;
  logic         in_known, in_err;

  rat_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .prod(mul_p));
  rat_gcd u_gcd (.clk, .rst, .start(gcd_start), .a_in(n_m), .b_in(d_m),
                 .done(gcd_done), .g(gcd_g));
  rat_div u_div (.clk, .rst, .start(div_start), .num(div_num), .den(g_val),
                 .done(div_done), .quo(div_q));

  // operand magnitudes
  assign in_num_ext = in.operand_num[31] ? M'(-{1'b1, in.operand_num})
                                         : M'({1'b0, in.operand_num});
  assign in_den_ext = in.operand_den[31] ? M'(-{1'b1, in.operand_den})
                                         : M'({1'b0, in.operand_den});
  assign t2 = mul_p[W-1:0];
  assign t2_s = (mode == rat_pkg::MODE_SUB) ? !on_s : on_s;

  // incoming mode and zero checks
  assign in_known = (in.mode <= rat_pkg::MODE_DIV);
  assign in_err   = (in_den_ext == '0) ||
                    (in.mode == rat_pkg::MODE_DIV && in_num_ext == '0);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out.status     = status;
  assign out.result_num = acc_num;
  assign out.result_den = acc_den[30:0];

  // multiplier operand select per step
  always_comb begin
    mul_a = ad_m;
    mul_b = od_m;
    case (state)
      S_M1: begin
        if (mode == rat_pkg::MODE_MUL) begin mul_a = an_m; mul_b = on_m; end
        else begin mul_a = an_m; mul_b = od_m; end
      end
      S_M2: begin
        if (mode == rat_pkg::MODE_DIV) begin mul_a = ad_m; mul_b = on_m; end
        else if (mode == rat_pkg::MODE_MUL) begin mul_a = ad_m; mul_b = od_m; end
        else begin mul_a = on_m; mul_b = ad_m; end
      end
      default: begin mul_a = ad_m; mul_b = od_m; end
    endcase
  end

  // start pulses for the serial units
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_start <= 1'b0;
      gcd_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= (state == S_IDLE && in_valid && in_known && !in_err &&
                    in.mode != rat_pkg::MODE_LOAD) ||
                   (state == S_M1 && mul_done) ||
                   (state == S_M2 && mul_done &&
                    !(mode inside {rat_pkg::MODE_MUL, rat_pkg::MODE_DIV}));
      gcd_start <= (state == S_IDLE && in_valid && in_known && !in_err &&
                    in.mode == rat_pkg::MODE_LOAD) ||
                   (state == S_M2 && mul_done &&
                    (mode inside {rat_pkg::MODE_MUL, rat_pkg::MODE_DIV})) ||
                   (state == S_M3 && mul_done);
      div_start <= (state == S_GCD && gcd_done) || (state == S_DN && div_done);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      acc_num <= '0;
      acc_den <= 32'd1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode   <= in.mode;
            on_s   <= in.operand_num[31];
            od_s   <= in.operand_den[31];
            on_m   <= in_num_ext;
            od_m   <= in_den_ext;
            an_s   <= acc_num[31];
            an_m   <= acc_num[31] ? M'(-{1'b1, acc_num}) : M'({1'b0, acc_num});
            ad_m   <= {1'b0, acc_den};
            if (!in_known) begin
              status <= rat_pkg::ST_OK;
              state  <= S_OUT;
            end else if (in_err) begin
              status <= rat_pkg::ST_ZERO;
              state  <= S_OUT;
            end else if (in.mode == rat_pkg::MODE_LOAD) begin
              status <= rat_pkg::ST_OK;
              n_s <= in.operand_num[31] != in.operand_den[31];
              n_m <= W'(in_num_ext);
              d_m <= W'(in_den_ext);
              state <= S_GCD;
            end else begin
              status <= rat_pkg::ST_OK;
              state <= S_M1;
            end
          end
        end
        // first product: an*od (add/sub/div), an*on (mul)
        S_M1: begin
          if (mul_done) begin
            t1 <= t2;
            t1_s <= (mode == rat_pkg::MODE_MUL) ? (an_s != on_s) : (an_s != od_s);
            state <= S_M2;
          end
        end
        // second product; acc denominator is always positive
        S_M2: begin
          if (mul_done) begin
            if (mode == rat_pkg::MODE_DIV) begin
              n_s <= t1_s != on_s;
              n_m <= t1;
              d_m <= t2;
              state <= S_GCD;
            end else if (mode == rat_pkg::MODE_MUL) begin
              n_s <= t1_s != od_s;
              n_m <= t1;
              d_m <= t2;
              state <= S_GCD;
            end else begin
              if (t1_s == t2_s) begin n_s <= t1_s; n_m <= t1 + t2; end
              else if (t1 >= t2) begin n_s <= t1_s; n_m <= t1 - t2; end
              else begin n_s <= t2_s; n_m <= t2 - t1; end
              state <= S_M3;
            end
          end
        end
        // third product: denominator ad*od
        S_M3: begin
          if (mul_done) begin
            n_s <= n_s != od_s;
            d_m <= t2;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            g_val <= gcd_g;
            div_num <= n_m;
            state <= S_DN;
          end
        end
        S_DN: begin
          if (div_done) begin
            n_m <= div_q;
            div_num <= d_m;
            state <= S_DD;
          end
        end
        S_DD: begin
          if (div_done) begin
            d_m <= div_q;
            state <= S_CHK;
          end
        end
        // sign fixup and range check
        S_CHK: begin
          if (d_m > LIM - W'(1) || n_m > ((n_s && n_m != '0) ? LIM : LIM - W'(1)))
            status <= rat_pkg::ST_OVF;
          else begin
            acc_num <= (n_s && n_m != '0) ? -32'(n_m) : 32'(n_m);
            acc_den <= 32'(d_m);
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[src/rat_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rat_mul: bit-serial unsigned multiplier
// Shift-and-add, one multiplier bit per cycle, 33 x 33 to 66 bits.
// ----------------------------------------------------------------------------
module rat_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rat_pkg::MAG_W-1:0]     a,
  input  logic [rat_pkg::MAG_W-1:0]     b,
  output logic                          done,
  output logic [2*rat_pkg::MAG_W-1:0]   prod
);
  logic [2*rat_pkg::MAG_W-1:0] mcand;
  logic [rat_pkg::MAG_W-1:0]   mplier;
  logic [5:0]                  cnt;
  logic                        busy;

  // one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      mcand  <= {{rat_pkg::MAG_W{1'b0}}, a};
      mplier <= b;
      prod   <= '0;
      cnt    <= 6'(rat_pkg::MAG_W);
      done   <= 1'b0;
    end else if (busy) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      cnt    <= cnt - 6'd1;
      busy   <= (cnt != 6'd1);
      done   <= (cnt == 6'd1);
    end else begin
      done <= 1'b0;
    end
  end
endmodule

[src/rat_gcd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rat_gcd: binary gcd unit
// Stein's algorithm, one shift or one subtract per cycle, gcd(0,x) = x.
// ----------------------------------------------------------------------------
module rat_gcd (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rat_pkg::WIDE_W-1:0]  a_in,
  input  logic [rat_pkg::WIDE_W-1:0]  b_in,
  output logic                        done,
  output logic [rat_pkg::WIDE_W-1:0]  g
);
  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_TWO  = 2'd1;
  localparam logic [1:0] G_ODD  = 2'd2;
  localparam logic [1:0] G_SUB  = 2'd3;

  logic [1:0]                 state;
  logic [rat_pkg::WIDE_W-1:0] a, b;
  logic [6:0]                 k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        G_IDLE: begin
          if (start) begin
            a <= a_in;
            b <= b_in;
            k <= '0;
            if (a_in == '0) begin
              g <= b_in; done <= 1'b1;
            end else if (b_in == '0) begin
              g <= a_in; done <= 1'b1;
            end else begin
              done  <= 1'b0;
              state <= G_TWO;
            end
          end else begin
            done <= 1'b0;
          end
        end
        // strip common factors of two
        G_TWO: begin
          done <= 1'b0;
          if (a[0] | b[0]) state <= G_ODD;
          else begin
            a <= a >> 1; b <= b >> 1; k <= k + 7'd1;
          end
        end
        G_ODD: begin
          done <= 1'b0;
          if (a[0]) state <= G_SUB;
          else a <= a >> 1;
        end
        // a odd; reduce b
        G_SUB: begin
          if (!b[0]) begin
            b <= b >> 1; done <= 1'b0;
          end else if (a > b) begin
            a <= b; b <= a - b; done <= 1'b0;
          end else if (b - a == '0) begin
            g <= a << k; done <= 1'b1; state <= G_IDLE;
          end else begin
            b <= b - a; done <= 1'b0;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= G_IDLE;
        end
      endcase
    end
  end
endmodule

[src/rat_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rat_div: restoring divider
// One quotient bit per cycle, exact division of a magnitude by the gcd.
// ----------------------------------------------------------------------------
module rat_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rat_pkg::WIDE_W-1:0]  num,
  input  logic [rat_pkg::WIDE_W-1:0]  den,
  output logic                        done,
  output logic [rat_pkg::WIDE_W-1:0]  quo
);
  logic [rat_pkg::WIDE_W:0]   rem;
  logic [rat_pkg::WIDE_W:0]   trial;
  logic [rat_pkg::WIDE_W-1:0] d;
  logic [6:0]                 cnt;
  logic                       busy;

  assign trial = {rem[rat_pkg::WIDE_W-1:0], quo[rat_pkg::WIDE_W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= '0;
      quo  <= num;
      d    <= den;
      cnt  <= 7'(rat_pkg::WIDE_W);
      done <= 1'b0;
    end else if (busy) begin
      // shift in next dividend bit, subtract if it fits
      if (!trial[rat_pkg::WIDE_W]) begin
        rem <= trial;
        quo <= {quo[rat_pkg::WIDE_W-2:0], 1'b1};
      end else begin
        rem <= {rem[rat_pkg::WIDE_W-1:0], quo[rat_pkg::WIDE_W-1]};
        quo <= {quo[rat_pkg::WIDE_W-2:0], 1'b0};
      end
      cnt  <= cnt - 7'd1;
      busy <= (cnt != 7'd1);
      done <= (cnt == 7'd1);
    end else begin
      done <= 1'b0;
    end
  end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for rational_accumulator_alu
// Drives fraction operations through the input channel and checks every
// result against an in-bench model of the reduced rational accumulator.
// Covers directed corner cases, backpressure, drain pauses and random traffic.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  rat_pkg::in_item_t  in = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rat_pkg::out_item_t out;

  rational_accumulator_alu u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in(in),
    .out_valid(out_valid), .out_ready(out_ready), .out(out)
  );

  always #10 clk = ~clk;

  // model state of the accumulator
  longint    acc_num = 0;
  longint    acc_den = 1;
  rat_pkg::out_item_t pending_results[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        status_seen[3] = '{0, 0, 0};
  bit        idle_on = 1'b1;
  bit        long_hold_req = 1'b0;

  // binary gcd, gcd(0,x) = x
  function automatic bit [63:0] gcd_u64(bit [63:0] a, bit [63:0] b);
    int k;
    bit [63:0] t;
    k = 0;
    if (a == 0) return b;
    if (b == 0) return a;
    while (((a | b) & 1) == 0) begin
      a >>= 1; b >>= 1; k++;
    end
    while ((a & 1) == 0) a >>= 1;
    do begin
      while ((b & 1) == 0) b >>= 1;
      if (a > b) begin
        t = a; a = b; b = t;
      end
      b -= a;
    end while (b != 0);
    return a << k;
  endfunction

  function automatic bit [63:0] mag32(logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
  endfunction

  // one operation on the model accumulator, returns the expected result
  function automatic rat_pkg::out_item_t rational_step(rat_pkg::in_item_t it);
    bit on_s, od_s, an_s, s1, s2, n_s, d_s;
    bit [63:0] on_m, od_m, an_m, ad_m, p1, p2, n_m, d_m, g;
    bit [63:0] lim;
    rat_pkg::out_item_t r;
    lim = 64'h8000_0000;
    on_s = it.operand_num[31]; on_m = mag32(it.operand_num);
    od_s = it.operand_den[31]; od_m = mag32(it.operand_den);
    an_s = acc_num < 0;
    an_m = an_s ? 64'(-acc_num) : 64'(acc_num);
    ad_m = 64'(acc_den);
    n_s = 0; n_m = 0; d_s = 0; d_m = 1;
    r.status = rat_pkg::ST_OK;
    if (it.mode <= rat_pkg::MODE_DIV) begin
      if (od_m == 0 || (it.mode == rat_pkg::MODE_DIV && on_m == 0)) begin
        r.status = rat_pkg::ST_ZERO;
      end else begin
        case (it.mode)
          rat_pkg::MODE_LOAD: begin
            n_s = on_s; n_m = on_m; d_s = od_s; d_m = od_m;
          end
          rat_pkg::MODE_ADD, rat_pkg::MODE_SUB: begin
            s1 = an_s ^ od_s; p1 = an_m * od_m;
            s2 = on_s; p2 = on_m * ad_m;
            if (it.mode == rat_pkg::MODE_SUB) s2 = !s2;
            if (s1 == s2) begin
              n_s = s1; n_m = p1 + p2;
            end else if (p1 >= p2) begin
              n_s = s1; n_m = p1 - p2;
            end else begin
              n_s = s2; n_m = p2 - p1;
            end
            d_s = od_s; d_m = ad_m * od_m;
          end
          rat_pkg::MODE_MUL: begin
            n_s = an_s ^ on_s; n_m = an_m * on_m;
            d_s = od_s; d_m = ad_m * od_m;
          end
          default: begin
            n_s = an_s ^ od_s; n_m = an_m * od_m;
            d_s = on_s; d_m = ad_m * on_m;
          end
        endcase
        g = gcd_u64(n_m, d_m);
        n_m /= g;
        d_m /= g;
        n_s = (n_m != 0) && (n_s != d_s);
        if (d_m > lim - 1 || n_m > (n_s ? lim : lim - 1)) begin
          r.status = rat_pkg::ST_OVF;
        end else begin
          acc_num = n_s ? -longint'(n_m) : longint'(n_m);
          acc_den = longint'(d_m);
        end
      end
    end
    r.result_num = acc_num[31:0];
    r.result_den = acc_den[30:0];
    return r;
  endfunction

  // send one transfer; valid stays high afterwards until a gap or drain
  task automatic send_op(logic [2:0] mode, logic [31:0] num, logic [31:0] den);
    rat_pkg::in_item_t it;
    int gap;
    it.mode = mode; it.operand_num = num; it.operand_den = den;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(rational_step(it));
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls plus an occasional long hold-off
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      stall_left = idle_on ? $urandom_range(0, 6) : 0;
      out_ready <= (stall_left == 0);
    end else if (!out_ready) begin
      if (stall_left > 0) stall_left--;
      out_ready <= (stall_left == 0);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    rat_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d num %0d den %0d",
               out.status, out.result_num, out.result_den);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (want.status <= rat_pkg::ST_ZERO) status_seen[want.status]++;
        if (out.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out.status);
          mismatches++;
        end
        if (out.result_num !== want.result_num) begin
          $error("result_num: expected %0d actual %0d", want.result_num, out.result_num);
          mismatches++;
        end
        if (out.result_den !== want.result_den) begin
          $error("result_den: expected %0d actual %0d", want.result_den, out.result_den);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_value(bit nonzero);
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 60) v = 32'($urandom_range(0, 2000)) - 32'd1000;
    else if (r < 85) v = $urandom;
    else begin
      case ($urandom_range(0, 4))
        0: v = 32'd0;
        1: v = 32'd1;
        2: v = 32'hffff_ffff;
        3: v = INT_MAX;
        default: v = INT_MIN;
      endcase
    end
    if (nonzero && v == 0 && $urandom_range(0, 9) != 0) v = 32'd1;
    return v;
  endfunction

  // reset state, each mode and every special case
  task automatic test_directed();
    send_op(3'd5, 32'd7, 32'd3);
    send_op(rat_pkg::MODE_LOAD, 32'd3, -32'sd6);
    send_op(rat_pkg::MODE_ADD, 32'd1, 32'd3);
    send_op(rat_pkg::MODE_SUB, 32'd5, -32'sd7);
    send_op(rat_pkg::MODE_MUL, -32'sd4, 32'd9);
    send_op(rat_pkg::MODE_DIV, 32'd2, 32'd5);
    send_op(rat_pkg::MODE_DIV, 32'd0, 32'd5);
    send_op(rat_pkg::MODE_LOAD, 32'd4, 32'd0);
    send_op(rat_pkg::MODE_ADD, 32'd4, 32'd0);
    send_op(rat_pkg::MODE_SUB, 32'd4, 32'd0);
    send_op(rat_pkg::MODE_MUL, 32'd4, 32'd0);
    send_op(rat_pkg::MODE_DIV, 32'd4, 32'd0);
    send_op(rat_pkg::MODE_MUL, 32'd0, 32'd7);
    send_op(rat_pkg::MODE_LOAD, INT_MIN, 32'd1);
    send_op(rat_pkg::MODE_SUB, 32'd1, 32'd1);
    send_op(rat_pkg::MODE_LOAD, INT_MAX, 32'd1);
    send_op(rat_pkg::MODE_ADD, 32'd1, 32'd1);
    send_op(rat_pkg::MODE_LOAD, 32'd1, INT_MIN);
    send_op(rat_pkg::MODE_LOAD, INT_MIN, INT_MIN);
    send_op(rat_pkg::MODE_DIV, INT_MIN, 32'd1);
    send_op(rat_pkg::MODE_LOAD, 32'd1, INT_MAX);
    send_op(rat_pkg::MODE_MUL, INT_MAX, 32'hffff_ffff);
    send_op(3'd6, $urandom, $urandom);
    send_op(3'd7, $urandom, $urandom);
    drain();
  endtask

  // long result hold-off while operations keep coming
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (6) send_op(rat_pkg::MODE_ADD, rand_value(0), rand_value(1));
    drain();
  endtask

  task automatic test_random(int count);
    int done;
    int r;
    logic [2:0] mode;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 3) mode = 3'($urandom_range(5, 7));
      else if (r < 18) mode = rat_pkg::MODE_LOAD;
      else mode = 3'($urandom_range(1, 4));
      send_op(mode, rand_value(0), rand_value(1));
      if (mode <= rat_pkg::MODE_DIV) done++;
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(700);
    idle_on = 1'b0;
    test_random(200);
    idle_on = 1'b1;
    test_backpressure();
    test_random(600);
    $display("ran %0d operations: %0d ok, %0d overflow, %0d zero-denominator results",
             items_sent, status_seen[0], status_seen[1], status_seen[2]);
    $display("directed corners, long result stall, drain pauses and random traffic");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
